FILE: hdl/yrc_pkg.sv
// yrc_pkg: shared types, constants and helpers for the YUV to RGB converter.
// Used by every module under hdl/; depends on nothing else.
`default_nettype none

package yrc_pkg;

    // Queue sizing
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FORMAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_FIRST   = 1'b1;

    // Input format codes
    localparam logic FMT_444  = 1'b0;
    localparam logic FMT_UYVY = 1'b1;

    // Arithmetic: every intermediate fits a 20 bit signed word
    localparam int SUM_W = 20;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam sum_t K_LUMA     = 20'sd298;
    localparam sum_t K_RED_V    = 20'sd409;
    localparam sum_t K_GREEN_U  = 20'sd100;
    localparam sum_t K_GREEN_V  = 20'sd208;
    localparam sum_t K_BLUE_U   = 20'sd516;
    localparam sum_t ROUND_HALF = 20'sd128;
    localparam sum_t LUMA_OFS   = 20'sd16;
    localparam logic [7:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       frame_end_in;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] green_byte;
        logic [7:0] byte_two;
        logic       last_of_item;
        logic       frame_end_out;
    } out_beat_t;

    typedef struct packed {
        logic input_format;
        logic blue_first;
    } cfg_t;

    // One pixel of work between front and back
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       last;
        logic       frame_end;
        logic       blue_first;
    } pix_cmd_t;

    // Floor shift by 8 with saturation to 0..255
    function automatic logic [7:0] clamp_chan(input sum_t s);
        logic [7:0] res;
        if (s[SUM_W-1])
            res = 8'd0;
        else if (s[SUM_W-2:16] != '0)
            res = CHAN_MAX;
        else
            res = s[15:8];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/yuv_to_rgb_converter_top.sv
// yuv_to_rgb_converter_top: top level of the BT.601 YUV to RGB converter.
// Depends on yrc_pkg, yrc_front, yrc_cmd_queue and yrc_back.
`default_nettype none

// BT.601 video-range YUV to 8-bit RGB converter. Input beats are pushed while
// full is low; each beat is one 4:4:4 pixel (input_format = 0) or a UYVY pair
// (input_format = 1) that gives two pixels sharing U and V, Y0 first. Results
// are read like a FIFO: the oldest pixel sits on result while empty is low and
// leaves on pop. Channels use R=(C+409E+128)>>8, G=(C-100D-208E+128)>>8,
// B=(C+516D+128)>>8 with C=298(Y-16), D=U-128, E=V-128, clamped to 0..255;
// blue_first picks B,G,R (reset) or R,G,B byte order. last_of_item marks the
// final pixel of each beat and carries frame_end through as frame_end_out.
// Throughput is one pixel per clock while result keeps being popped, set by
// the single color matrix in the back end: a 4:4:4 beat is taken every cycle,
// and a UYVY beat is held until both of its pixels are issued. Each pixel
// passes the input register, command queue, product stage and result FIFO in
// turn; Y0 of a UYVY pair goes ahead of Y1, both waiting while result stalls.
// Config writes (cfg_ready is always high) must be made while the
// block is idle; register 0 is input_format, register 1 is blue_first.

module yuv_to_rgb_converter_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input beats
    input  wire logic                             push,
    output logic                                  full,
    input  wire yrc_pkg::in_beat_t                item,
    // result beats
    output logic                                  empty,
    input  wire logic                             pop,
    output yrc_pkg::out_beat_t                    result,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [yrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic                             cfg_data
);

    yrc_pkg::cfg_t cfg_reg, cfg_next;

    logic              cmd_wr, cmd_rd, cmd_full, cmd_empty;
    yrc_pkg::pix_cmd_t cmd_in, cmd_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                yrc_pkg::CFG_INPUT_FORMAT: cfg_next.input_format = cfg_data;
                yrc_pkg::CFG_BLUE_FIRST:   cfg_next.blue_first   = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_format <= yrc_pkg::FMT_444;
            cfg_reg.blue_first   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: holds a beat; one pixel command per cycle unless cmd_full
    yrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_wr   (cmd_wr),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    // decouples front and back so each can stall on its own
    yrc_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_rd),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // back end: color matrix and result FIFO
    yrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_rd    (cmd_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: hdl/yrc_cmd_queue.sv
// yrc_cmd_queue: small FIFO of pixel commands between front and back.
// Depends on yrc_pkg.
`default_nettype none

module yrc_cmd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire yrc_pkg::pix_cmd_t  wr_data,
    output logic                    full,
    input  wire logic               rd_en,
    output yrc_pkg::pix_cmd_t       rd_data,
    output logic                    empty
);

    yrc_pkg::pix_cmd_t mem_reg [yrc_pkg::CMD_DEPTH];

    logic [yrc_pkg::CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [yrc_pkg::CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [yrc_pkg::CMD_CNT_W-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign full    = (count_reg == yrc_pkg::CMD_CNT_W'(yrc_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == yrc_pkg::CMD_PTR_W'(yrc_pkg::CMD_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == yrc_pkg::CMD_PTR_W'(yrc_pkg::CMD_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

FILE: hdl/yrc_front.sv
// yrc_front: input stage; holds one item and splits it into pixel commands.
// Depends on yrc_pkg.
`default_nettype none

module yrc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire yrc_pkg::cfg_t      cfg,
    input  wire logic               push,
    output logic                    full,
    input  wire yrc_pkg::in_beat_t  item,
    output logic                    cmd_wr,
    output yrc_pkg::pix_cmd_t       cmd,
    input  wire logic               cmd_full
);

    yrc_pkg::in_beat_t item_reg;
    logic fmt_reg, bf_reg;
    logic hold_reg, hold_next;
    logic phase_reg, phase_next;   // 1 = second pixel of a UYVY pair
    logic issue, last_pix, last_issue, accept;

    assign issue      = hold_reg && !cmd_full;
    assign last_pix   = (fmt_reg == yrc_pkg::FMT_444) || phase_reg;
    assign last_issue = issue && last_pix;
    assign full       = hold_reg && !last_issue;
    assign accept     = push && !full;

    assign cmd_wr          = issue;
    assign cmd.luma        = phase_reg ? item_reg.luma_second : item_reg.luma_first;
    assign cmd.chroma_blue = item_reg.chroma_blue;
    assign cmd.chroma_red  = item_reg.chroma_red;
    assign cmd.last        = last_pix;
    assign cmd.frame_end   = last_pix && item_reg.frame_end_in;
    assign cmd.blue_first  = bf_reg;

    always_comb
    begin
        hold_next  = hold_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            hold_next  = 1'b1;
            phase_next = 1'b0;
        end
        else if (last_issue)
        begin
            hold_next  = 1'b0;
            phase_next = 1'b0;
        end
        else if (issue)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            hold_reg  <= hold_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            fmt_reg  <= cfg.input_format;
            bf_reg   <= cfg.blue_first;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/yrc_back.sv
// yrc_back: color matrix (registered product stage, combinational sum/clamp) and result FIFO.
// Depends on yrc_pkg.
`default_nettype none

module yrc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_empty,
    input  wire yrc_pkg::pix_cmd_t  cmd,
    output logic                    cmd_rd,
    output logic                    empty,
    input  wire logic               pop,
    output yrc_pkg::out_beat_t      result
);

    // Product stage
    logic s1_valid_reg;
    yrc_pkg::sum_t c_reg, rv_reg, gu_reg, gv_reg, bu_reg;
    logic s1_last_reg, s1_fend_reg, s1_bf_reg;

    yrc_pkg::sum_t y_off, d_off, e_off;
    yrc_pkg::sum_t r_sum, g_sum, b_sum;
    logic [7:0] r_ch, g_ch, b_ch;
    yrc_pkg::out_beat_t res_in;

    // Result FIFO
    yrc_pkg::out_beat_t res_mem_reg [yrc_pkg::RES_DEPTH];
    logic [yrc_pkg::RES_PTR_W-1:0] res_wr_ptr_reg, res_wr_ptr_next;
    logic [yrc_pkg::RES_PTR_W-1:0] res_rd_ptr_reg, res_rd_ptr_next;
    logic [yrc_pkg::RES_CNT_W-1:0] res_count_reg, res_count_next;
    logic [yrc_pkg::RES_CNT_W-1:0] res_used;
    logic res_wr, res_rd;

    // Room is reserved for the pixel in the product stage
    assign res_used = res_count_reg + yrc_pkg::RES_CNT_W'(s1_valid_reg);
    assign cmd_rd   = !cmd_empty
                      && (res_used < yrc_pkg::RES_CNT_W'(yrc_pkg::RES_DEPTH));

    // U-128 and V-128 are the inputs with the top bit flipped
    assign y_off = yrc_pkg::sum_t'(signed'({1'b0, cmd.luma})) - yrc_pkg::LUMA_OFS;
    assign d_off = yrc_pkg::sum_t'(signed'({~cmd.chroma_blue[7], cmd.chroma_blue[6:0]}));
    assign e_off = yrc_pkg::sum_t'(signed'({~cmd.chroma_red[7], cmd.chroma_red[6:0]}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= cmd_rd;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_rd)
        begin
            c_reg       <= y_off * yrc_pkg::K_LUMA;
            rv_reg      <= e_off * yrc_pkg::K_RED_V;
            gu_reg      <= d_off * yrc_pkg::K_GREEN_U;
            gv_reg      <= e_off * yrc_pkg::K_GREEN_V;
            bu_reg      <= d_off * yrc_pkg::K_BLUE_U;
            s1_last_reg <= cmd.last;
            s1_fend_reg <= cmd.frame_end;
            s1_bf_reg   <= cmd.blue_first;
        end
    end

    assign r_sum = c_reg + rv_reg + yrc_pkg::ROUND_HALF;
    assign g_sum = c_reg - gu_reg - gv_reg + yrc_pkg::ROUND_HALF;
    assign b_sum = c_reg + bu_reg + yrc_pkg::ROUND_HALF;
    assign r_ch  = yrc_pkg::clamp_chan(r_sum);
    assign g_ch  = yrc_pkg::clamp_chan(g_sum);
    assign b_ch  = yrc_pkg::clamp_chan(b_sum);

    assign res_in.byte_zero     = s1_bf_reg ? b_ch : r_ch;
    assign res_in.green_byte    = g_ch;
    assign res_in.byte_two      = s1_bf_reg ? r_ch : b_ch;
    assign res_in.last_of_item  = s1_last_reg;
    assign res_in.frame_end_out = s1_fend_reg;

    assign res_wr = s1_valid_reg;
    assign empty  = (res_count_reg == '0);
    assign res_rd = pop && !empty;
    assign result = res_mem_reg[res_rd_ptr_reg];

    always_comb
    begin
        res_wr_ptr_next = res_wr_ptr_reg;
        res_rd_ptr_next = res_rd_ptr_reg;
        res_count_next  = res_count_reg;
        if (res_wr)
        begin
            res_wr_ptr_next = (res_wr_ptr_reg == yrc_pkg::RES_PTR_W'(yrc_pkg::RES_DEPTH - 1))
                              ? '0 : res_wr_ptr_reg + 1'b1;
        end
        if (res_rd)
        begin
            res_rd_ptr_next = (res_rd_ptr_reg == yrc_pkg::RES_PTR_W'(yrc_pkg::RES_DEPTH - 1))
                              ? '0 : res_rd_ptr_reg + 1'b1;
        end
        if (res_wr && !res_rd)
            res_count_next = res_count_reg + 1'b1;
        else if (res_rd && !res_wr)
            res_count_next = res_count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            res_wr_ptr_reg <= res_wr_ptr_next;
            res_rd_ptr_reg <= res_rd_ptr_next;
            res_count_reg  <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
            res_mem_reg[res_wr_ptr_reg] <= res_in;
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_yuv_to_rgb_converter_top.sv
// tb_yuv_to_rgb_converter_top: self-checking bench for the YUV to RGB converter.
// Depends on yrc_pkg and yuv_to_rgb_converter_top; drives directed and random
// beats under both input formats and byte orders and checks every pixel.
`default_nettype none

module tb_yuv_to_rgb_converter_top;
    import yrc_pkg::*;

    // Margin that lets the pipeline drain before config writes
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 240;
    localparam int PRESSURE_ITEMS = 64;
    localparam int HOLD_CYCLES    = 150;
    localparam int END_WAIT       = 5000;
    localparam int RUN_LIMIT      = 2000000;

    // One directed row: register setting, the input beat and, where it can
    // be read off by hand, the single pixel it must give
    typedef struct packed {
        logic      fmt;
        logic      bgr;
        in_beat_t  beat;
        logic      known;
        out_beat_t want;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      push      = 1'b0;
    logic      full;
    in_beat_t  item      = '0;
    logic      empty;
    logic      pop       = 1'b0;
    out_beat_t result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_INPUT_FORMAT;
    logic      cfg_data  = 1'b0;

    // Shadow copy of the block's registers, at their reset values
    logic      cur_format = FMT_444;
    logic      cur_bgr    = 1'b1;

    out_beat_t pending_pixels[$];
    stim_row_t stim_rows[$];
    int        error_count  = 0;
    bit        hold_request = 1'b0;

    yuv_to_rgb_converter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #RUN_LIMIT;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Pixel predictor
    // ---------------------------------------------------------------------

    // Floor divide by 256, saturated to 0..255
    function automatic logic [7:0] chan_sat(input int s);
        int q;
        logic [7:0] res;
        q = s / 256;
        if (s < 0)
            res = 8'd0;
        else if (q > 255)
            res = 8'd255;
        else
            res = q[7:0];
        return res;
    endfunction

    function automatic out_beat_t rgb_pixel(input logic [7:0] y, input logic [7:0] u,
                                            input logic [7:0] v, input logic bgr,
                                            input logic last, input logic fend);
        int yi, ui, vi, c, d, e;
        logic [7:0] red, green, blue;
        out_beat_t px;
        yi = int'(y);
        ui = int'(u);
        vi = int'(v);
        c = 298 * (yi - 16);
        d = ui - 128;
        e = vi - 128;
        red   = chan_sat(c + 409 * e + 128);
        green = chan_sat(c - 100 * d - 208 * e + 128);
        blue  = chan_sat(c + 516 * d + 128);
        px.byte_zero     = bgr ? blue : red;
        px.green_byte    = green;
        px.byte_two      = bgr ? red : blue;
        px.last_of_item  = last;
        px.frame_end_out = fend;
        return px;
    endfunction

    // Append one pixel to the tail of the expected list
    task automatic expect_pixel(input out_beat_t px);
        pending_pixels.insert(pending_pixels.size(), px);
    endtask

    // Expected pixels of one accepted beat under the current registers.
    // A UYVY pair gives Y0 then Y1 with shared chroma; only the second
    // pixel closes the beat and carries the frame end.
    task automatic queue_pixels(input in_beat_t b);
        if (cur_format == FMT_444)
        begin
            expect_pixel(rgb_pixel(b.luma_first, b.chroma_blue, b.chroma_red,
                                   cur_bgr, 1'b1, b.frame_end_in));
        end
        else
        begin
            expect_pixel(rgb_pixel(b.luma_first, b.chroma_blue, b.chroma_red,
                                   cur_bgr, 1'b0, 1'b0));
            expect_pixel(rgb_pixel(b.luma_second, b.chroma_blue, b.chroma_red,
                                   cur_bgr, 1'b1, b.frame_end_in));
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Mostly zero, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Full range, with a bias toward the video-range limits and mid-scale
    function automatic logic [7:0] rand_sample();
        logic [7:0] s;
        if ($urandom_range(0, 7) != 0)
            s = 8'($urandom_range(0, 255));
        else
        begin
            case ($urandom_range(0, 5))
                0:       s = 8'd0;
                1:       s = 8'd16;
                2:       s = 8'd128;
                3:       s = 8'd235;
                4:       s = 8'd240;
                default: s = 8'd255;
            endcase
        end
        return s;
    endfunction

    function automatic in_beat_t rand_beat();
        in_beat_t b;
        b.luma_first   = rand_sample();
        b.luma_second  = rand_sample();
        b.chroma_blue  = rand_sample();
        b.chroma_red   = rand_sample();
        b.frame_end_in = ($urandom_range(0, 15) == 0);
        return b;
    endfunction

    function automatic stim_row_t mk_row(input logic fmt, input logic bgr,
                                         input int y0, input int y1,
                                         input int u, input int v,
                                         input int fe, input int known,
                                         input int e0, input int eg,
                                         input int e2);
        stim_row_t r;
        r.fmt   = fmt;
        r.bgr   = bgr;
        r.beat  = {y0[7:0], y1[7:0], u[7:0], v[7:0], fe[0]};
        r.known = known[0];
        r.want  = {e0[7:0], eg[7:0], e2[7:0], 1'b1, fe[0]};
        return r;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input stim_row_t r);
        stim_rows.insert(stim_rows.size(), r);
    endtask

    // Offer one beat and hold it until taken. push is left high so that a
    // following beat can go out back to back.
    task automatic send_beat(input in_beat_t b);
        item <= b;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles != 0)
        begin
            push <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Registers change only with the block drained: wait out every pixel,
    // then the pipeline depth, then write both registers back to back.
    task automatic apply_config(input logic fmt, input logic bgr);
        int n;
        push <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (n = 0; n < 2; n++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (n == 0) ? CFG_INPUT_FORMAT : CFG_BLUE_FIRST;
            cfg_data  <= (n == 0) ? fmt : bgr;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_format = fmt;
        cur_bgr    = bgr;
    endtask

    // ---------------------------------------------------------------------
    // Directed table. Known rows: black, white, below-black and above-white
    // luma, saturated chroma corners and the same pixel in both byte orders.
    // ---------------------------------------------------------------------
    initial
    begin
        // reset setting: 4:4:4, B,G,R
        add_row(mk_row(FMT_444, 1'b1,  16,   0, 128, 128, 0, 1,   0,   0,   0));
        add_row(mk_row(FMT_444, 1'b1, 235,   0, 128, 128, 0, 1, 255, 255, 255));
        add_row(mk_row(FMT_444, 1'b1,   0,   0, 128, 128, 1, 1,   0,   0,   0));
        add_row(mk_row(FMT_444, 1'b1, 255, 255, 128, 128, 0, 1, 255, 255, 255));
        add_row(mk_row(FMT_444, 1'b1,  16,   0,   0,   0, 0, 1,   0, 154,   0));
        add_row(mk_row(FMT_444, 1'b1,  16,   0, 255, 255, 0, 1, 255,   0, 203));
        add_row(mk_row(FMT_444, 1'b1,  16,   0,   0, 255, 0, 1,   0,   0, 203));
        // second luma must not matter in 4:4:4
        add_row(mk_row(FMT_444, 1'b1, 128,   0, 128, 128, 0, 0,   0,   0,   0));
        add_row(mk_row(FMT_444, 1'b1, 128, 255, 128, 128, 0, 0,   0,   0,   0));
        add_row(mk_row(FMT_444, 1'b1, 128, 170,  90, 200, 1, 0,   0,   0,   0));
        // R,G,B order
        add_row(mk_row(FMT_444, 1'b0,  16,   0, 255, 255, 0, 1, 203,   0, 255));
        add_row(mk_row(FMT_444, 1'b0,  81,  85,  90, 240, 0, 0,   0,   0,   0));
        add_row(mk_row(FMT_444, 1'b0, 255,   0,   0,   0, 1, 0,   0,   0,   0));
        // UYVY pairs in both orders
        add_row(mk_row(FMT_UYVY, 1'b0,   0, 255, 128, 128, 0, 0, 0, 0, 0));
        add_row(mk_row(FMT_UYVY, 1'b0,  16, 235,   0, 255, 1, 0, 0, 0, 0));
        add_row(mk_row(FMT_UYVY, 1'b1, 255,   0, 255,   0, 0, 0, 0, 0, 0));
        add_row(mk_row(FMT_UYVY, 1'b1, 128, 129, 128, 128, 1, 0, 0, 0, 0));
        add_row(mk_row(FMT_UYVY, 1'b1,  41, 210, 240, 110, 0, 0, 0, 0, 0));
        // back to the reset setting, frame end on a known pixel
        add_row(mk_row(FMT_444, 1'b1, 235,   0, 128, 128, 1, 1, 255, 255, 255));
    end

    // ---------------------------------------------------------------------
    // Sender: directed rows, then random phases over every register setting
    // ---------------------------------------------------------------------
    initial
    begin
        int        i, phase, k, waited;
        stim_row_t row;
        in_beat_t  b;
        logic      no_gap;

        wait (rst_n);
        @(posedge clk);

        for (i = 0; i < stim_rows.size(); i++)
        begin
            row = stim_rows[i];
            if (row.fmt !== cur_format || row.bgr !== cur_bgr)
                apply_config(row.fmt, row.bgr);
            send_beat(row.beat);
            if (row.known)
                expect_pixel(row.want);
            else
                queue_pixels(row.beat);
            idle_sender(pick_gap());
        end

        // Phase bits pick format and byte order, so each setting runs twice
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_config(phase[0] ? FMT_UYVY : FMT_444, phase[1]);
            // Phase 3 opens with a long receiver stall while beats keep
            // coming, so the block backs up and raises full.
            if (phase == 3)
                hold_request = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                b = rand_beat();
                send_beat(b);
                queue_pixels(b);
                no_gap = (phase == 3 && k < PRESSURE_ITEMS) || phase == 6;
                if (!no_gap)
                    idle_sender(pick_gap());
            end
        end

        push <= 1'b0;
        waited = 0;
        while (pending_pixels.size() != 0 && waited < END_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        // extra cycles catch any pixel beyond the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $display("%0t: %0d expected pixels never arrived", $time, pending_pixels.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: random pop gaps and bursts, plus one long hold-off on request
    // ---------------------------------------------------------------------
    initial
    begin
        int gap, burst;
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap != 0)
                begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            pop <= 1'b1;
            burst = $urandom_range(1, 24);
            repeat (burst) @(posedge clk);
        end
    end

    // ---------------------------------------------------------------------
    // Checker: every popped beat against the oldest expected pixel
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none actual %h", $time, result);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("byte_zero", want.byte_zero, result.byte_zero);
                check_field("green_byte", want.green_byte, result.green_byte);
                check_field("byte_two", want.byte_two, result.byte_two);
                check_field("last_of_item", {7'd0, want.last_of_item},
                            {7'd0, result.last_of_item});
                check_field("frame_end_out", {7'd0, want.frame_end_out},
                            {7'd0, result.frame_end_out});
            end
        end
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/yrc_pkg.sv
hdl/yrc_cmd_queue.sv
hdl/yrc_front.sv
hdl/yrc_back.sv
hdl/yuv_to_rgb_converter_top.sv
tb/sv/tb_yuv_to_rgb_converter_top.sv
